// ===== hdl/pmfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfr_pkg
// Shared types, field widths and codes of the page map with free run search.
// ----------------------------------------------------------------------------
package pmfr_pkg;

    // Widths of the request and result fields as they travel on the ports.
    localparam int ACTION_W = 2;
    localparam int PAGE_W   = 10;
    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // The run counter looks at this many pages of a table word per cycle.
    localparam int CHUNK_LOG  = 3;
    localparam int CHUNK_BITS = 1 << CHUNK_LOG;

    // Request kinds.
    localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FALLBACK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTHING  = 2'd3;

    // Outcome of counting free pages over one chunk of a table word.
    typedef struct packed {
        logic                 hit;          // the run reached the wanted length
        logic                 hit_in_chunk; // that run started inside this chunk
        logic [CHUNK_LOG-1:0] hit_pos;      // its start position in the chunk
        logic                 tail_new;     // the open run started in this chunk
        logic [CHUNK_LOG-1:0] tail_pos;     // its start position in the chunk
        logic [COUNT_W-1:0]   count;        // length of the open run afterwards
    } t_run_res;

endpackage

// ===== hdl/pmfr_ram.sv =====
// ----------------------------------------------------------------------------
// pmfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pmfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pmfr_run_step.sv =====
// ----------------------------------------------------------------------------
// pmfr_run_step
// Counts free pages over one chunk of a table word and spots the first run
// of the wanted length.
// ----------------------------------------------------------------------------
module pmfr_run_step
    import pmfr_pkg::*;
(
    input  logic [CHUNK_BITS-1:0] i_used,   // present bit of each page
    input  logic [CHUNK_BITS-1:0] i_mask,   // page lies inside the table
    input  logic [COUNT_W-1:0]    i_count,  // open run length coming in
    input  logic [COUNT_W-1:0]    i_want,
    output t_run_res              o_res
);

    // Walk the chunk in page order; positions outside the table are skipped.
    always_comb begin
        t_run_res res;
        res       = '0;
        res.count = i_count;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            if (i_mask[i] && !res.hit) begin
                if (!i_used[i]) begin
                    if (res.count == '0) begin
                        res.tail_new = 1'b1;
                        res.tail_pos = CHUNK_LOG'(i);
                    end
                    res.count = res.count + 1'b1;
                    if (res.count == i_want && i_want != '0) begin
                        res.hit          = 1'b1;
                        res.hit_in_chunk = res.tail_new;
                        res.hit_pos      = res.tail_pos;
                    end
                end else begin
                    res.count = '0;
                end
            end
        end
        o_res = res;
    end

endmodule

// ===== hdl/page_map_with_free_run_search_top.sv =====
// ----------------------------------------------------------------------------
// page_map_with_free_run_search_top
// Two-level page map with map, unmap and first-fit free run search.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the action, tdata the
// page number, frame number and wanted run length. Each request gives one
// result on the m_axis channel with status, start page, released frame and
// released flag. One request is worked on at a time; s_axis_tready is high
// only while the sequencer is idle.
// Map and unmap step through the page to slot split through a reciprocal
// multiply (S_DIV1, S_DIV2), one table word read, one read-modify-write and
// the load of the output register. Other actions, and a map or unmap of a
// page out of range, go straight to the load of the output register.
// Find walks the directory slot by slot; a present table costs one word read
// plus a pass over its pages by the single run counter that steps eight pages
// a cycle, while an absent slot, or any slot when the wanted length is zero,
// moves straight on to the next slot.
// The result sits in an output register, so a new request is accepted while
// it waits; a request that finishes while that register is still full holds
// in its last step until the receiver takes the earlier result.
// Reset clears the directory present bits; a table word is only used once its
// slot is present, so no clearing pass runs and the block is ready at once.
// ----------------------------------------------------------------------------
module page_map_with_free_run_search_top
    import pmfr_pkg::*;
#(
    parameter int DIR_SLOTS   = 16,
    parameter int TABLE_SLOTS = 64,
    parameter int FRAME_BITS  = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: page_number[9:0], frame_number[29:10],
    // run_length[40:30], zero fill.
    input  logic [47:0] s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: status[1:0], start_page[11:2],
    // released_frame[31:12], released_valid[32], zero fill.
    output logic [39:0] m_axis_tdata
);

    localparam int TOTAL     = DIR_SLOTS * TABLE_SLOTS;
    localparam int SLOT_AW   = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
    localparam int SCNT_W    = $clog2(DIR_SLOTS + 1);
    localparam int IDX_AW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PAGE_AW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PCNT_W    = $clog2(TOTAL + 1);
    localparam int CHUNKS    = (TABLE_SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int KW        = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int POS_W     = KW + CHUNK_LOG;
    localparam int ROW_PAD   = (1 << KW) * CHUNK_BITS;
    localparam int DIV_SHIFT = 21;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / TABLE_SLOTS;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV1   = 8'b0000_0010,
        S_DIV2   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_MODIFY = 8'b0001_0000,
        S_FSLOT  = 8'b0010_0000,
        S_FCHUNK = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Request fields.
    logic [ACTION_W-1:0]   r_action;
    logic [PAGE_W-1:0]     r_page;
    logic [FRAME_BITS-1:0] r_frame;
    logic [COUNT_W-1:0]    r_want;

    // Page split.
    logic [31:0]        r_prod;
    logic [SLOT_AW-1:0] r_slot;
    logic [IDX_AW-1:0]  r_idx;

    // Find state.
    logic [SCNT_W-1:0]  r_s;
    logic [KW-1:0]      r_k;
    logic [PCNT_W-1:0]  r_pbase;
    logic [PCNT_W-1:0]  r_first;
    logic [COUNT_W-1:0] r_count;
    logic               r_abs_found;
    logic [PCNT_W-1:0]  r_abs_page;

    // Directory present bits.
    logic [DIR_SLOTS-1:0] r_slot_present;

    // Staged and output results.
    logic [STATUS_W-1:0]   r_res_status;
    logic [PAGE_W-1:0]     r_res_start;
    logic [FRAME_BITS-1:0] r_res_frame;
    logic                  r_res_valid;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [PAGE_W-1:0]     r_out_start;
    logic [FRAME_W-1:0]    r_out_frame;
    logic                  r_out_valid_frame;

    // Memory ports.
    logic                  row_we, row_re;
    logic [SLOT_AW-1:0]    row_raddr;
    logic [TABLE_SLOTS-1:0] row_wdata, row_rdata;
    logic                  frm_we, frm_re;
    logic [PAGE_AW-1:0]    frm_addr;
    logic [FRAME_BITS-1:0] frm_rdata;

    logic                   s_accept;
    logic                   out_load;
    logic                   in_range;
    logic [PAGE_W-1:0]      q0;
    logic [20:0]            qt;
    logic [11:0]            rem;
    logic                   slot_ok;
    logic [TABLE_SLOTS-1:0] row_cur;
    logic                   page_used;
    logic [ROW_PAD-1:0]     row_pad;
    logic [CHUNK_BITS-1:0]  chunk_used;
    logic [CHUNK_BITS-1:0]  chunk_mask;
    logic [PCNT_W-1:0]      chunk_base;
    t_run_res               run;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign in_range      = {11'd0, s_axis_tdata[9:0]} < 21'(TOTAL);

    // Page to slot and index through a reciprocal with one correction step.
    assign q0  = r_prod[DIV_SHIFT +: PAGE_W];
    assign qt  = 21'(q0) * 21'(TABLE_SLOTS);
    assign rem = 12'(r_page) - 12'(qt);

    // Table word of the addressed page; an absent slot holds no pages.
    assign slot_ok   = r_slot_present[r_slot];
    assign row_cur   = slot_ok ? row_rdata : '0;
    assign page_used = row_cur[r_idx];

    // Chunk of the table word that the run counter sees this cycle.
    assign row_pad    = ROW_PAD'(row_rdata);
    assign chunk_used = row_pad[{r_k, CHUNK_LOG'(0)} +: CHUNK_BITS];
    assign chunk_base = PCNT_W'(r_pbase + PCNT_W'({r_k, CHUNK_LOG'(0)}));
    always_comb begin
        for (int i = 0; i < CHUNK_BITS; i++) begin
            chunk_mask[i] = {1'b0, r_k, CHUNK_LOG'(i)} < (POS_W + 1)'(TABLE_SLOTS);
        end
    end

    pmfr_run_step u_run_step (
        .i_used  (chunk_used),
        .i_mask  (chunk_mask),
        .i_count (r_count),
        .i_want  (r_want),
        .o_res   (run)
    );

    // Memory port control.
    assign row_re    = (r_state == S_READ) ||
                       ((r_state == S_FSLOT) && (r_s != SCNT_W'(DIR_SLOTS)));
    assign row_raddr = (r_state == S_READ) ? r_slot : r_s[SLOT_AW-1:0];
    assign row_we    = (r_state == S_MODIFY) &&
                       ((r_action == ACT_MAP) || page_used);
    assign row_wdata = (r_action == ACT_MAP) ? (row_cur | (TABLE_SLOTS'(1) << r_idx))
                                             : (row_cur & ~(TABLE_SLOTS'(1) << r_idx));
    assign frm_re    = (r_state == S_READ);
    assign frm_we    = (r_state == S_MODIFY) && (r_action == ACT_MAP);
    assign frm_addr  = PAGE_AW'(r_page);

    pmfr_ram #(
        .WIDTH (TABLE_SLOTS),
        .DEPTH (DIR_SLOTS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_slot),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    pmfr_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (TOTAL)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_addr),
        .i_wdata (r_frame),
        .i_re    (frm_re),
        .i_raddr (frm_addr),
        .o_rdata (frm_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (s_axis_tuser) inside
                        ACT_MAP, ACT_UNMAP: n_state = in_range ? S_DIV1 : S_DONE;
                        ACT_FIND:           n_state = S_FSLOT;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_DIV1:   n_state = S_DIV2;
            S_DIV2:   n_state = S_READ;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: n_state = S_DONE;
            S_FSLOT: begin
                if (r_s == SCNT_W'(DIR_SLOTS)) begin
                    n_state = S_DONE;
                end else if (r_slot_present[r_s[SLOT_AW-1:0]] && r_want != '0) begin
                    n_state = S_FCHUNK;
                end
            end
            S_FCHUNK: begin
                if (run.hit) begin
                    n_state = S_DONE;
                end else if (r_k == KW'(CHUNKS - 1)) begin
                    n_state = S_FSLOT;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slot_present <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_MODIFY) && (r_action == ACT_MAP)) begin
                r_slot_present[r_slot] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_action     <= s_axis_tuser;
                    r_page       <= s_axis_tdata[9:0];
                    r_frame      <= FRAME_BITS'(s_axis_tdata[29:10]);
                    r_want       <= s_axis_tdata[40:30];
                    r_s          <= '0;
                    r_pbase      <= '0;
                    r_count      <= '0;
                    r_abs_found  <= 1'b0;
                    r_res_status <= (s_axis_tuser == ACT_MAP)   ? ST_NONE :
                                    (s_axis_tuser == ACT_UNMAP) ? ST_NOTHING : ST_DONE;
                    r_res_start  <= '0;
                    r_res_frame  <= '0;
                    r_res_valid  <= 1'b0;
                end
            end
            S_DIV1: begin
                r_prod <= 32'({22'd0, r_page} * 32'(DIV_RECIP));
            end
            S_DIV2: begin
                if (rem >= 12'(TABLE_SLOTS)) begin
                    r_slot <= SLOT_AW'(q0 + 1'b1);
                    r_idx  <= IDX_AW'(rem - 12'(TABLE_SLOTS));
                end else begin
                    r_slot <= SLOT_AW'(q0);
                    r_idx  <= IDX_AW'(rem);
                end
            end
            S_READ: begin
            end
            S_MODIFY: begin
                // Map always succeeds; unmap reports the frame the page held.
                if (r_action == ACT_MAP) begin
                    r_res_status <= ST_DONE;
                end else if (page_used) begin
                    r_res_status <= ST_DONE;
                    r_res_frame  <= frm_rdata;
                    r_res_valid  <= (frm_rdata != '0);
                end else begin
                    r_res_status <= ST_NOTHING;
                end
            end
            S_FSLOT: begin
                if (r_s == SCNT_W'(DIR_SLOTS)) begin
                    // No run found: fall back to the lowest absent slot.
                    if (r_abs_found) begin
                        r_res_status <= ST_FALLBACK;
                        r_res_start  <= PAGE_W'(r_abs_page);
                    end else begin
                        r_res_status <= ST_NONE;
                    end
                end else if (!r_slot_present[r_s[SLOT_AW-1:0]]) begin
                    // An absent table breaks the run.
                    r_count <= '0;
                    if (!r_abs_found) begin
                        r_abs_found <= 1'b1;
                        r_abs_page  <= r_pbase;
                    end
                    r_s     <= r_s + 1'b1;
                    r_pbase <= PCNT_W'(r_pbase + PCNT_W'(TABLE_SLOTS));
                end else if (r_want == '0) begin
                    r_s     <= r_s + 1'b1;
                    r_pbase <= PCNT_W'(r_pbase + PCNT_W'(TABLE_SLOTS));
                end else begin
                    r_k <= '0;
                end
            end
            S_FCHUNK: begin
                if (run.hit) begin
                    r_res_status <= ST_DONE;
                    r_res_start  <= run.hit_in_chunk
                                    ? PAGE_W'(chunk_base + PCNT_W'(run.hit_pos))
                                    : PAGE_W'(r_first);
                end else begin
                    r_count <= run.count;
                    if (run.tail_new) begin
                        r_first <= PCNT_W'(chunk_base + PCNT_W'(run.tail_pos));
                    end
                    if (r_k == KW'(CHUNKS - 1)) begin
                        r_s     <= r_s + 1'b1;
                        r_pbase <= PCNT_W'(r_pbase + PCNT_W'(TABLE_SLOTS));
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status      <= r_res_status;
            r_out_start       <= r_res_start;
            r_out_frame       <= FRAME_W'(r_res_frame);
            r_out_valid_frame <= r_res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_valid_frame, r_out_frame, r_out_start, r_out_status};

    // A flagged release always carries a nonzero frame with status done.
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_valid_frame) |-> (r_out_status == ST_DONE && r_out_frame != '0))
        else $error("released flag without a nonzero frame");

    // The sequencer takes no second request right after one is accepted.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("request accepted while busy");

    // The open run stays shorter than the wanted length while searching.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FSLOT || r_state == S_FCHUNK) && r_want != '0) |-> (r_count < r_want))
        else $error("run count passed the wanted length");

    // The slot walk never passes the end of the directory.
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSLOT || r_state == S_FCHUNK) |-> (r_s <= SCNT_W'(DIR_SLOTS)))
        else $error("slot walk out of range");

    // A table word is scanned only for a present slot.
    a_scan_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHUNK) |-> r_slot_present[r_s[SLOT_AW-1:0]])
        else $error("scan of an absent table");

endmodule
